// ----- rtl/core/hcb_pkg.sv -----
package hcb_pkg;

    localparam logic [6:0] LINE_MAX  = 7'd80;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    typedef enum logic [1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_BAD_ADDR = 2'd2,
        CMD_CLEARED  = 2'd3
    } t_cmd_kind;

    typedef enum logic [1:0] {
        PH_ADDR  = 2'd0,
        PH_VALUE = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic        valid;
        t_cmd_kind   kind;
        logic [31:0] address;
        logic [31:0] data;
    } t_result;

endpackage

// ----- rtl/core/hcb_in_stage.sv -----
module hcb_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_char;
    logic       w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // hold the character until the parser takes it
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

// ----- rtl/core/hcb_parser.sv -----
module hcb_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_char,
    output hcb_pkg::t_result o_result
);

    hcb_pkg::t_phase r_phase;
    hcb_pkg::t_phase n_phase;
    logic [31:0]     r_addr;
    logic [31:0]     n_addr;
    logic [31:0]     r_value;
    logic [31:0]     n_value;
    logic [6:0]      r_count;
    logic [6:0]      n_count;

    logic [7:0]      w_lc;
    logic            w_is_digit;
    logic [3:0]      w_digit;
    logic [6:0]      w_count_inc;

    always_comb begin
        w_lc       = i_char | hcb_pkg::CASE_FOLD;
        w_is_digit = 1'b0;
        w_digit    = 4'd0;
        if (w_lc inside {[8'h30:8'h39]}) begin
            w_is_digit = 1'b1;
            w_digit    = w_lc[3:0];
        end else if (w_lc inside {[8'h61:8'h66]}) begin
            w_is_digit = 1'b1;
            w_digit    = 4'(w_lc[3:0] + 4'd9);
        end
    end

    assign w_count_inc = r_count + 7'd1;

    always_comb begin
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_value  = r_value;
        n_count  = r_count;
        o_result = '{valid: 1'b0, kind: hcb_pkg::CMD_READ, address: 32'd0, data: 32'd0};
        if (i_take) begin
            if (i_char == hcb_pkg::CHAR_CR) begin
                o_result.valid   = 1'b1;
                o_result.address = r_addr;
                if (r_phase == hcb_pkg::PH_ADDR) begin
                    o_result.kind = hcb_pkg::CMD_READ;
                end else if (r_addr[1:0] != 2'b00) begin
                    o_result.kind = hcb_pkg::CMD_BAD_ADDR;
                end else begin
                    o_result.kind = hcb_pkg::CMD_WRITE;
                    o_result.data = r_value;
                end
                n_phase = hcb_pkg::PH_ADDR;
                n_addr  = 32'd0;
                n_value = 32'd0;
                n_count = 7'd0;
            end else begin
                case (r_phase)
                    hcb_pkg::PH_ADDR: begin
                        if (w_is_digit) begin
                            n_addr = {r_addr[27:0], w_digit};
                        end else begin
                            n_phase = hcb_pkg::PH_VALUE;
                        end
                    end
                    hcb_pkg::PH_VALUE: begin
                        if (w_is_digit) begin
                            n_value = {r_value[27:0], w_digit};
                        end else begin
                            n_phase = hcb_pkg::PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                n_count = w_count_inc;
                // drop the line once it reaches the limit
                if (w_count_inc >= hcb_pkg::LINE_MAX) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = hcb_pkg::CMD_CLEARED;
                    n_phase = hcb_pkg::PH_ADDR;
                    n_addr  = 32'd0;
                    n_value = 32'd0;
                    n_count = 7'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hcb_pkg::PH_ADDR;
            r_addr  <= 32'd0;
            r_value <= 32'd0;
            r_count <= 7'd0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_value <= n_value;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/core/hcb_out_reg.sv -----
module hcb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hcb_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_address,
    output logic [31:0]      o_data
);

    logic               r_valid;
    logic               n_valid;
    hcb_pkg::t_cmd_kind r_kind;
    logic [31:0]        r_address;
    logic [31:0]        r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_kind    <= i_result.kind;
            r_address <= i_result.address;
            r_data    <= i_result.data;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_address = r_address;
    assign o_data    = r_data;

endmodule

// ----- rtl/core/hex_command_bus_bridge_core.sv -----
// Hex command line parser for a bus monitor.
// Input channel: one received character per transfer on i_char_in, with
// i_in_valid / o_in_ready. Output channel: one command per transfer on
// o_cmd_kind (read, write, bad address, line cleared), o_bus_address and
// o_bus_data, with o_out_valid / i_out_ready.
// A carriage return produces one command; the character that brings the
// line to 80 characters produces a line-cleared command. Other characters
// produce nothing.
// Path: the character is captured in the input register at its transfer and
// is then parsed into the result register, which drives o_out_valid, once
// that register is free or being emptied.
// Throughput: one character per cycle while the output side is free.
// A stalled receiver holds the result register; one more character is held
// in the input register, after which o_in_ready drops until the result is
// taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the start of an empty line.
module hex_command_bus_bridge_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_cmd_kind,
    output logic [31:0] o_bus_address,
    output logic [31:0] o_bus_data
);

    logic             w_char_valid;
    logic [7:0]       w_char;
    logic             w_take;
    hcb_pkg::t_result w_result;

    // advance when the result register is free or being emptied
    assign w_take = w_char_valid && (!o_out_valid || i_out_ready);

    hcb_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_char  (i_char_in),
        .i_take  (w_take),
        .o_valid (w_char_valid),
        .o_char  (w_char)
    );

    hcb_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_char   (w_char),
        .o_result (w_result)
    );

    hcb_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (w_result),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_kind    (o_cmd_kind),
        .o_address (o_bus_address),
        .o_data    (o_bus_data)
    );

endmodule

// ----- dv/hex_command_bus_bridge_core_tb.sv -----
module hex_command_bus_bridge_core_tb;

    import hcb_pkg::*;

    localparam int TOTAL_CHARS = 1950;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] address;
        logic [31:0] data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        cmd_t       want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_cmd_kind;
    logic [31:0] o_bus_address;
    logic [31:0] o_bus_data;

    t_phase      line_phase;
    logic [31:0] addr_acc;
    logic [31:0] value_acc;
    logic [6:0]  line_len;

    cmd_t        pending_cmds [$];
    cmd_t        no_cmd;
    int          chars_sent;
    int          errors;
    bit          no_idle;

    dir_row_t    dir_rows [20];

    hex_command_bus_bridge_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd_kind    (o_cmd_kind),
        .o_bus_address (o_bus_address),
        .o_bus_data    (o_bus_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit is_hex(input logic [7:0] raw);
        logic [7:0] c;
        c = raw | CASE_FOLD;
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic void clear_parser();
        line_phase = PH_ADDR;
        addr_acc   = 32'd0;
        value_acc  = 32'd0;
        line_len   = 7'd0;
    endfunction

    // Advance the line parser by one character; return 1 when a command results.
    function automatic bit parse_char(input logic [7:0] raw, output cmd_t cmd);
        logic [7:0] c;
        logic [3:0] nib;
        cmd = '{CMD_READ, 32'd0, 32'd0};
        if (raw == CHAR_CR) begin
            cmd.address = addr_acc;
            if (line_phase == PH_ADDR) begin
                cmd.kind = CMD_READ;
            end else if (addr_acc[1:0] != 2'b00) begin
                cmd.kind = CMD_BAD_ADDR;
            end else begin
                cmd.kind = CMD_WRITE;
                cmd.data = value_acc;
            end
            clear_parser();
            return 1'b1;
        end
        c   = raw | CASE_FOLD;
        nib = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
        case (line_phase)
            PH_ADDR: begin
                if (is_hex(raw)) addr_acc = {addr_acc[27:0], nib};
                else line_phase = PH_VALUE;
            end
            PH_VALUE: begin
                if (is_hex(raw)) value_acc = {value_acc[27:0], nib};
                else line_phase = PH_DONE;
            end
            default: ;
        endcase
        line_len = line_len + 7'd1;
        if (line_len >= LINE_MAX) begin
            cmd = '{CMD_CLEARED, 32'd0, 32'd0};
            clear_parser();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] digit_byte(input logic [3:0] n);
        if (n < 4'd10) return ($urandom_range(0, 3) == 0) ? 8'h10 + n : 8'h30 + n;
        return $urandom_range(0, 1) ? 8'h41 + n - 8'd10 : 8'h61 + n - 8'd10;
    endfunction

    function automatic logic [7:0] sep_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_hex(b) || b == CHAR_CR);
        return b;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
        return b;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic typed, input cmd_t want);
        cmd_t got;
        bit   has;
        no_idle = (chars_sent >= 800 && chars_sent < 1100);
        while (!no_idle && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        has = parse_char(ch, got);
        if (typed) pending_cmds.push_back(want);
        else if (has) pending_cmds.push_back(got);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cmds.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_line();
        logic [7:0] line_q [$];
        int         kind;
        int         n;
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
            repeat (n) line_q.push_back(digit_byte(4'($urandom_range(0, 15))));
            if (n > 0 && $urandom_range(0, 9) < 7)
                line_q[n-1] = digit_byte(4'(4 * $urandom_range(0, 3)));
            line_q.push_back(sep_byte());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
            repeat (n) line_q.push_back(digit_byte(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 3) == 0) begin
                line_q.push_back(sep_byte());
                repeat ($urandom_range(0, 4)) line_q.push_back(plain_byte());
            end
            line_q.push_back(CHAR_CR);
        end else if (kind < 74) begin
            repeat ($urandom_range(0, 10)) line_q.push_back(digit_byte(4'($urandom_range(0, 15))));
            line_q.push_back(CHAR_CR);
        end else if (kind < 78) begin
            repeat ($urandom_range(78, 84)) line_q.push_back(plain_byte());
            if ($urandom_range(0, 1)) line_q.push_back(CHAR_CR);
        end else begin
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        foreach (line_q[k]) send_char(line_q[k], 1'b0, no_cmd);
    endtask

    task automatic report(input string what, input cmd_t want, input cmd_t got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected kind %0d addr %h data %h, got kind %0d addr %h data %h",
                     $realtime, what, want.kind, want.address, want.data,
                     got.kind, got.address, got.data);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin : chk_out
        cmd_t got;
        cmd_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{t_cmd_kind'(o_cmd_kind), o_bus_address, o_bus_data};
            if (pending_cmds.size() == 0) begin
                report("unexpected command", no_cmd, got);
            end else begin
                want = pending_cmds.pop_front();
                if (got.kind != want.kind || got.address != want.address ||
                    got.data != want.data)
                    report("command mismatch", want, got);
            end
        end
    end

    initial begin
        bit paused;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_in   = 8'h00;
        i_out_ready = 1'b0;
        no_cmd      = '{CMD_READ, 32'd0, 32'd0};
        chars_sent  = 0;
        errors      = 0;
        no_idle     = 1'b0;
        paused      = 1'b0;
        clear_parser();
        dir_rows = '{
            '{8'h0D, 1'b1, '{CMD_READ,     32'h0000_0000, 32'h0000_0000}},
            '{8'h66, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h43, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h2C, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h37, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h0D, 1'b1, '{CMD_WRITE,    32'h0000_00FC, 32'h0000_0007}},
            '{8'h31, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h20, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h0D, 1'b1, '{CMD_BAD_ADDR, 32'h0000_0001, 32'h0000_0000}},
            '{8'h10, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h46, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'hFF, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h19, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h00, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h39, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h8D, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h0D, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h40, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h66, 1'b0, '{CMD_READ,     32'h0,         32'h0}},
            '{8'h0D, 1'b1, '{CMD_WRITE,    32'h0000_0000, 32'h0000_000F}}
        };
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k]) send_char(dir_rows[k].ch, dir_rows[k].typed, dir_rows[k].want);
        hold_until_drained();
        while (chars_sent < TOTAL_CHARS) begin
            if (!paused && chars_sent >= 1300) begin
                hold_until_drained();
                paused = 1'b1;
            end
            random_line();
        end
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hcb_pkg.sv
rtl/core/hcb_in_stage.sv
rtl/core/hcb_parser.sv
rtl/core/hcb_out_reg.sv
rtl/core/hex_command_bus_bridge_core.sv
dv/hex_command_bus_bridge_core_tb.sv
